// ----- hw/rtl/tppi_pkg.sv -----
// ----------------------------------------------------------------------------
// tppi_pkg
// Shared constants, operation codes and the table request type of the
// tabulated pair potential interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tppi_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TABLE_ROWS = 1024;
	localparam int PAIR_TYPES = 4;
	localparam int COLUMNS    = PAIR_TYPES * PAIR_TYPES;
	localparam int COL_W      = 4;
	localparam int ROW_IN_W   = 10;
	localparam int COL_AW     = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(TABLE_ROWS);

	localparam int BANK_ROWS  = (TABLE_ROWS + 2) / 3;
	localparam int BANK_DEPTH = BANK_ROWS * COLUMNS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	localparam int DIV3_S     = ROW_W + 1;
	localparam int DIV3_M     = ((1 << DIV3_S) + 2) / 3;

	localparam logic [1:0] OP_EVAL         = 2'd0;
	localparam logic [1:0] OP_WRITE_ENTRY  = 2'd1;
	localparam logic [1:0] OP_WRITE_COLUMN = 2'd2;
	localparam logic [1:0] OP_UNUSED       = 2'd3;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [ROW_W-1:0] q;
		logic [1:0]       m;
		logic [COL_W-1:0] col;
	} tbl_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tppi_table.sv -----
// ----------------------------------------------------------------------------
// tppi_table
// Potential table split into three banks by row modulo three, so that the
// three consecutive rows of one interpolation are read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tppi_table (
	input  wire logic                   clk,
	input  wire tppi_pkg::tbl_req_t     req,
	input  wire logic [31:0]            wdata,
	output logic signed [31:0]          p0,
	output logic signed [31:0]          p1,
	output logic signed [31:0]          p2
);

	logic [1:0]  m_q;

	for (genvar b = 0; b < 3; b++) begin : g_bank
		logic [31:0]                   mem [tppi_pkg::BANK_DEPTH];
		logic [31:0]                   rdata_q;
		logic [tppi_pkg::ROW_W-1:0]    qb;
		logic [tppi_pkg::BANK_AW-1:0]  ra;
		logic [tppi_pkg::BANK_AW-1:0]  wa;

		always_comb begin
			qb = (2'(b) >= req.m) ? req.q : req.q + 1'b1;
			ra = tppi_pkg::BANK_AW'(qb) * tppi_pkg::BANK_AW'(tppi_pkg::COLUMNS)
				+ tppi_pkg::BANK_AW'(req.col);
			wa = tppi_pkg::BANK_AW'(req.q) * tppi_pkg::BANK_AW'(tppi_pkg::COLUMNS)
				+ tppi_pkg::BANK_AW'(req.col);
		end

		always_ff @(posedge clk) begin
			if (req.wr_en && req.m == 2'(b)) begin
				mem[wa] <= wdata;
			end
			if (req.rd_en) begin
				rdata_q <= mem[ra];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			m_q <= req.m;
		end
	end

	always_comb begin
		unique case (m_q)
			2'd1: begin
				p0 = g_bank[1].rdata_q;
				p1 = g_bank[2].rdata_q;
				p2 = g_bank[0].rdata_q;
			end
			2'd2: begin
				p0 = g_bank[2].rdata_q;
				p1 = g_bank[0].rdata_q;
				p2 = g_bank[1].rdata_q;
			end
			default: begin
				p0 = g_bank[0].rdata_q;
				p1 = g_bank[1].rdata_q;
				p2 = g_bank[2].rdata_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tabulated_pair_potential_interp.sv -----
// ----------------------------------------------------------------------------
// tabulated_pair_potential_interp
// Quadratic interpolation of a tabulated pair potential over squared
// distance, Q16.16, with saturated potential and gradient outputs.
//
// Items arrive on the in channel and are of three kinds: a table entry write,
// a column write (start, step and inverse step) and an evaluation. Only an
// evaluation yields a result on the out channel; writes yield none.
// The block takes one item per cycle while in_ready is high. A result is
// registered in every stage and then in the output register. Column data
// sits in a small memory read at the input transfer; the table sits in three
// banks read in the fourth stage, where table writes also take effect, so
// items act on the state strictly in order.
// When the receiver stalls, a waiting result stays in the output register
// and the pipeline behind it keeps filling its empty stages; in_ready falls
// only once every stage holds an item. Reset clears all valid flags; table
// and column contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tabulated_pair_potential_interp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire logic [tppi_pkg::COL_W-1:0]    column,
	input  wire logic [31:0]                   distance_sq,
	input  wire logic [tppi_pkg::ROW_IN_W-1:0] row,
	input  wire logic signed [31:0]            entry_value,
	input  wire logic [31:0]                   start_sq,
	input  wire logic [31:0]                   step_sq,
	input  wire logic [31:0]                   inverse_step,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 potential,
	output logic signed [31:0]                 gradient,
	output logic                               too_short,
	output logic                               beyond_table
);

	localparam int F   = tppi_pkg::FRAC_BITS;
	localparam int RW  = tppi_pkg::ROW_W;
	localparam int KW  = 64 - 2 * F;
	localparam int DW  = RW + 33;
	localparam int DMW = RW + 32;
	localparam int TW  = RW + 65 - F;
	localparam int CW  = F + 3;
	localparam int HW  = F + 4;
	localparam int AW  = HW + 35;
	localparam int BW  = CW + 33;
	localparam int CCW = CW + HW;
	localparam int INW = AW - F + 1;
	localparam int PPW = BW - F + 1;
	localparam int CSW = CCW - F;
	localparam int GTW = INW + 33 - F;
	localparam int EW  = CSW + 35;
	localparam int POW = EW - F;
	localparam int D3W = RW + tppi_pkg::DIV3_S;

	localparam logic [CW-2:0]          TWO_U   = (CW-1)'(1 << (F + 1));
	localparam logic signed [HW-1:0]   HALF_H  = HW'(1 << (F - 1));
	localparam logic signed [HW-1:0]   ONE_H   = HW'(1 << F);
	localparam logic signed [31:0]     S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0]     S32_MIN = 32'sh80000000;

	logic [10:1] ld;
	logic [9:1]  vld;
	logic        out_valid_q;

	logic [95:0] colmem [tppi_pkg::COLUMNS];
	logic [tppi_pkg::COL_AW-1:0] col_idx;
	logic        col_ok;

	// Stage 1
	logic ev_s1, we_s1, bad_s1;
	logic [tppi_pkg::COL_W-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [31:0] val_s1, r2_s1, start_s1, step_s1, istep_s1;
	// Stage 2
	logic ev_s2, we_s2, bad_s2, sh_s2;
	logic [tppi_pkg::COL_W-1:0] col_s2;
	logic [RW-1:0] row_s2;
	logic [31:0] val_s2, r2a_s2, step_s2, istep_s2;
	// Stage 3
	logic ev_s3, we_s3, bad_s3, sh_s3;
	logic [tppi_pkg::COL_W-1:0] col_s3;
	logic [RW-1:0] row_s3;
	logic [31:0] val_s3, r2a_s3, step_s3, istep_s3;
	logic [KW-1:0] k_s3;
	// Stage 4
	logic ev_s4, bt_s4, sh_s4;
	logic signed [DW-1:0] diff_s4;
	logic [31:0] istep_s4;
	// Stage 5
	logic ev_s5, bt_s5, sh_s5, dneg_s5;
	logic [DMW-1:0] phi_s5;
	logic [63:0] plo_s5;
	logic [31:0] istep_s5;
	logic signed [31:0] p0_s5;
	logic signed [32:0] dv_s5;
	logic signed [34:0] d2v_s5;
	// Stage 6
	logic ev_s6, bt_s6, sh_s6;
	logic signed [CW-1:0] chi_s6;
	logic signed [HW-1:0] chih_s6, chim1_s6;
	logic [31:0] istep_s6;
	logic signed [31:0] p0_s6;
	logic signed [32:0] dv_s6;
	logic signed [34:0] d2v_s6;
	// Stage 7
	logic ev_s7, bt_s7, sh_s7;
	logic signed [AW-1:0] a_s7;
	logic signed [BW-1:0] b_s7;
	logic signed [CCW-1:0] c_s7;
	logic [31:0] istep_s7;
	logic signed [31:0] p0_s7;
	logic signed [32:0] dv_s7;
	logic signed [34:0] d2v_s7;
	// Stage 8
	logic ev_s8, bt_s8, sh_s8;
	logic signed [INW-1:0] inner_s8;
	logic signed [PPW-1:0] pp1_s8;
	logic signed [CSW-1:0] cs_s8;
	logic [31:0] istep_s8;
	logic signed [34:0] d2v_s8;
	// Stage 9
	logic ev_s9, bt_s9, sh_s9, ineg_s9;
	logic [INW-1:0] ghi_s9;
	logic [63:0] glo_s9;
	logic signed [EW-1:0] e_s9;
	logic signed [PPW-1:0] pp1_s9;
	// Outputs
	logic signed [31:0] potential_q, gradient_q;
	logic too_short_q, beyond_table_q;

	// Combinational signals
	logic        sh_c;
	logic [31:0] r2a_c;
	logic [63:0] prod_c;
	logic [RW-1:0] kl_c, idx_c, q_c;
	logic [D3W-1:0] d3_c;
	logic [RW+1:0] q3_c;
	logic [1:0]  m_c;
	logic [DMW-1:0] ks_c;
	logic signed [DW-1:0] diff_c;
	logic        bt_c;
	tppi_pkg::tbl_req_t tbl_req;
	logic signed [31:0] p0_c, p1_c, p2_c;
	logic [DMW-1:0] dmag_c;
	logic signed [34:0] p0x_c, p1x_c, p2x_c;
	logic [TW-1:0] t_c;
	logic [CW-2:0] cm_c;
	logic signed [CW-1:0] chi_c;
	logic signed [AW-1:0] ra_c;
	logic signed [BW-1:0] rb_c;
	logic signed [CCW-1:0] rc_c;
	logic [INW-1:0] imag_c, m2_c;
	logic [GTW-1:0] gt_c;
	logic signed [GTW:0] gs_c;
	logic signed [EW-1:0] re_c;
	logic signed [POW-1:0] pot_c;
	logic signed [31:0] grad_sat_c, pot_sat_c;

	assign col_idx = tppi_pkg::COL_AW'(column);
	assign col_ok  = 32'(column) < 32'(tppi_pkg::COLUMNS);

	always_comb begin
		ld[10] = !out_valid_q || out_ready;
		for (int i = 9; i >= 1; i--) begin
			ld[i] = !vld[i] || ld[i+1];
		end
	end

	assign in_ready = ld[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld[1]) begin
				vld[1] <= in_valid && operation != tppi_pkg::OP_UNUSED;
			end
			for (int i = 2; i <= 9; i++) begin
				if (ld[i]) begin
					vld[i] <= vld[i-1];
				end
			end
			if (ld[10]) begin
				out_valid_q <= vld[9] && ev_s9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ld[1] && operation == tppi_pkg::OP_WRITE_COLUMN && col_ok) begin
			colmem[col_idx] <= {start_sq, step_sq, inverse_step};
		end
		if (ld[1]) begin
			{start_s1, step_s1, istep_s1} <= colmem[col_idx];
		end
	end

	always_comb begin
		sh_c   = r2_s1 < start_s1;
		r2a_c  = sh_c ? 32'd0 : r2_s1 - start_s1;
		prod_c = 64'(r2a_s2) * 64'(istep_s2);

		kl_c   = k_s3[RW-1:0];
		idx_c  = we_s3 ? row_s3 : kl_c;
		d3_c   = D3W'(idx_c) * D3W'(tppi_pkg::DIV3_M);
		q_c    = RW'(d3_c >> tppi_pkg::DIV3_S);
		q3_c   = (RW+2)'(q_c) * (RW+2)'(3);
		m_c    = 2'(idx_c - RW'(q3_c));
		ks_c   = DMW'(kl_c) * DMW'(step_s3);
		diff_c = $signed(DW'(r2a_s3)) - $signed(DW'(ks_c));
		bt_c   = bad_s3 || (k_s3 >= KW'(tppi_pkg::TABLE_ROWS - 2));

		tbl_req.rd_en = ld[4];
		tbl_req.wr_en = ld[4] && vld[3] && we_s3;
		tbl_req.q     = q_c;
		tbl_req.m     = m_c;
		tbl_req.col   = col_s3;
	end

	tppi_table u_table (
		.clk   (clk),
		.req   (tbl_req),
		.wdata (val_s3),
		.p0    (p0_c),
		.p1    (p1_c),
		.p2    (p2_c)
	);

	always_comb begin
		dmag_c = diff_s4[DW-1] ? DMW'(-diff_s4) : DMW'(diff_s4);
		p0x_c  = 35'(p0_c);
		p1x_c  = 35'(p1_c);
		p2x_c  = 35'(p2_c);

		t_c   = (TW'(phi_s5) << (32 - F)) + TW'(plo_s5 >> F);
		cm_c  = (t_c > TW'(TWO_U)) ? TWO_U : (CW-1)'(t_c);
		chi_c = dneg_s5 ? -$signed(CW'(cm_c)) : $signed(CW'(cm_c));

		ra_c = AW'(chih_s6) * AW'(d2v_s6);
		rb_c = BW'(chi_s6) * BW'(dv_s6);
		rc_c = CCW'(chi_s6) * CCW'(chim1_s6);

		imag_c = inner_s8[INW-1] ? INW'(-inner_s8) : INW'(inner_s8);
		m2_c   = {imag_c[INW-2:0], 1'b0};
		re_c   = EW'(cs_s8) * EW'(d2v_s8);

		gt_c = (GTW'(ghi_s9) << (32 - F)) + GTW'(glo_s9 >> F);
		gs_c = ineg_s9 ? -$signed((GTW+1)'(gt_c)) : $signed((GTW+1)'(gt_c));
		if (gs_c > (GTW+1)'(S32_MAX)) begin
			grad_sat_c = S32_MAX;
		end else if (gs_c < (GTW+1)'(S32_MIN)) begin
			grad_sat_c = S32_MIN;
		end else begin
			grad_sat_c = 32'(gs_c);
		end
		pot_c = POW'(pp1_s9)
			+ POW'((e_s9 + (e_s9[EW-1] ? EW'((1 << (F + 1)) - 1) : EW'(0))) >>> (F + 1));
		if (pot_c > POW'(S32_MAX)) begin
			pot_sat_c = S32_MAX;
		end else if (pot_c < POW'(S32_MIN)) begin
			pot_sat_c = S32_MIN;
		end else begin
			pot_sat_c = 32'(pot_c);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			ev_s1  <= operation == tppi_pkg::OP_EVAL;
			we_s1  <= operation == tppi_pkg::OP_WRITE_ENTRY && col_ok
				&& 32'(row) < 32'(tppi_pkg::TABLE_ROWS);
			bad_s1 <= !col_ok;
			col_s1 <= column;
			row_s1 <= RW'(row);
			val_s1 <= entry_value;
			r2_s1  <= distance_sq;
		end
		if (ld[2]) begin
			ev_s2    <= ev_s1;
			we_s2    <= we_s1;
			bad_s2   <= bad_s1;
			sh_s2    <= sh_c;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			val_s2   <= val_s1;
			r2a_s2   <= r2a_c;
			step_s2  <= step_s1;
			istep_s2 <= istep_s1;
		end
		if (ld[3]) begin
			ev_s3    <= ev_s2;
			we_s3    <= we_s2;
			bad_s3   <= bad_s2;
			sh_s3    <= sh_s2;
			col_s3   <= col_s2;
			row_s3   <= row_s2;
			val_s3   <= val_s2;
			r2a_s3   <= r2a_s2;
			step_s3  <= step_s2;
			istep_s3 <= istep_s2;
			k_s3     <= KW'(prod_c >> (2 * F));
		end
		if (ld[4]) begin
			ev_s4    <= ev_s3;
			bt_s4    <= bt_c;
			sh_s4    <= sh_s3 && !bad_s3;
			diff_s4  <= diff_c;
			istep_s4 <= istep_s3;
		end
		if (ld[5]) begin
			ev_s5    <= ev_s4;
			bt_s5    <= bt_s4;
			sh_s5    <= sh_s4;
			dneg_s5  <= diff_s4[DW-1];
			phi_s5   <= DMW'(dmag_c[DMW-1:32]) * DMW'(istep_s4);
			plo_s5   <= 64'(dmag_c[31:0]) * 64'(istep_s4);
			istep_s5 <= istep_s4;
			p0_s5    <= p0_c;
			dv_s5    <= 33'(p1x_c - p0x_c);
			d2v_s5   <= p2x_c - (p1x_c <<< 1) + p0x_c;
		end
		if (ld[6]) begin
			ev_s6    <= ev_s5;
			bt_s6    <= bt_s5;
			sh_s6    <= sh_s5;
			chi_s6   <= chi_c;
			chih_s6  <= HW'(chi_c) - HALF_H;
			chim1_s6 <= HW'(chi_c) - ONE_H;
			istep_s6 <= istep_s5;
			p0_s6    <= p0_s5;
			dv_s6    <= dv_s5;
			d2v_s6   <= d2v_s5;
		end
		if (ld[7]) begin
			ev_s7    <= ev_s6;
			bt_s7    <= bt_s6;
			sh_s7    <= sh_s6;
			a_s7     <= ra_c;
			b_s7     <= rb_c;
			c_s7     <= rc_c;
			istep_s7 <= istep_s6;
			p0_s7    <= p0_s6;
			dv_s7    <= dv_s6;
			d2v_s7   <= d2v_s6;
		end
		if (ld[8]) begin
			ev_s8    <= ev_s7;
			bt_s8    <= bt_s7;
			sh_s8    <= sh_s7;
			inner_s8 <= INW'((a_s7 + (a_s7[AW-1] ? AW'((1 << F) - 1) : AW'(0))) >>> F)
				+ INW'(dv_s7);
			pp1_s8   <= PPW'((b_s7 + (b_s7[BW-1] ? BW'((1 << F) - 1) : BW'(0))) >>> F)
				+ PPW'(p0_s7);
			cs_s8    <= CSW'((c_s7 + (c_s7[CCW-1] ? CCW'((1 << F) - 1) : CCW'(0))) >>> F);
			istep_s8 <= istep_s7;
			d2v_s8   <= d2v_s7;
		end
		if (ld[9]) begin
			ev_s9   <= ev_s8;
			bt_s9   <= bt_s8;
			sh_s9   <= sh_s8;
			ineg_s9 <= inner_s8[INW-1];
			ghi_s9  <= INW'(m2_c[INW-1:32]) * INW'(istep_s8);
			glo_s9  <= 64'(m2_c[31:0]) * 64'(istep_s8);
			e_s9    <= re_c;
			pp1_s9  <= pp1_s8;
		end
		if (ld[10]) begin
			potential_q    <= bt_s9 ? 32'sd0 : pot_sat_c;
			gradient_q     <= bt_s9 ? 32'sd0 : grad_sat_c;
			too_short_q    <= sh_s9;
			beyond_table_q <= bt_s9;
		end
	end

	assign out_valid    = out_valid_q;
	assign potential    = potential_q;
	assign gradient     = gradient_q;
	assign too_short    = too_short_q;
	assign beyond_table = beyond_table_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tppi_checker.sv -----
// ----------------------------------------------------------------------------
// tppi_checker
// Port-level checks of the tabulated pair potential interpolator, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module tppi_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [1:0]                    operation,
	input wire logic [tppi_pkg::COL_W-1:0]    column,
	input wire logic [31:0]                   distance_sq,
	input wire logic [tppi_pkg::ROW_IN_W-1:0] row,
	input wire logic signed [31:0]            entry_value,
	input wire logic [31:0]                   start_sq,
	input wire logic [31:0]                   step_sq,
	input wire logic [31:0]                   inverse_step,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [31:0]            potential,
	input wire logic signed [31:0]            gradient,
	input wire logic                          too_short,
	input wire logic                          beyond_table
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(column)
			&& $stable(distance_sq) && $stable(row) && $stable(entry_value)
			&& $stable(start_sq) && $stable(step_sq) && $stable(inverse_step))
		else $error("Input transfer withdrawn or changed while waiting.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result withdrawn before its transfer.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(potential) && $stable(gradient)
			&& $stable(too_short) && $stable(beyond_table))
		else $error("Result changed while stalled.");

	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beyond_table |-> potential == 32'sd0 && gradient == 32'sd0)
		else $error("Nonzero result beyond the table.");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("Result shown right after reset.");

endmodule

bind tabulated_pair_potential_interp tppi_checker u_tppi_checker (.*);

`default_nettype wire

// ----- sim/tb_tabulated_pair_potential_interp.sv -----
// ----------------------------------------------------------------------------
// tb_tabulated_pair_potential_interp
// Self-checking testbench for the tabulated pair potential interpolator. It
// keeps its own copy of the column data and the potential table. For every
// evaluation it computes the expected potential, gradient and flags, then
// compares them with each output transfer in order. Table rows are written
// before any evaluation reads them. Both sides idle at random, and the
// receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tabulated_pair_potential_interp;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS      = tppi_pkg::FRAC_BITS;
	localparam int TABLE_ROWS     = tppi_pkg::TABLE_ROWS;
	localparam int COLUMNS        = tppi_pkg::COLUMNS;
	localparam int COL_W          = tppi_pkg::COL_W;
	localparam int ROW_IN_W       = tppi_pkg::ROW_IN_W;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TOTAL_ITEMS    = 1200;
	localparam int RANDOM_ITEMS   = 850;

	typedef struct packed {
		logic signed [31:0] pot;
		logic signed [31:0] grad;
		logic               short_flag;
		logic               beyond_flag;
	} interp_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           operation;
	logic [COL_W-1:0]     column;
	logic [31:0]          distance_sq;
	logic [ROW_IN_W-1:0]  row;
	logic signed [31:0]   entry_value;
	logic [31:0]          start_sq;
	logic [31:0]          step_sq;
	logic [31:0]          inverse_step;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [31:0]   potential;
	logic signed [31:0]   gradient;
	logic                 too_short;
	logic                 beyond_table;

	logic signed [31:0] pot_table [TABLE_ROWS*COLUMNS];
	bit                 row_known [TABLE_ROWS*COLUMNS];
	logic [31:0]        col_start [COLUMNS];
	logic [31:0]        col_step  [COLUMNS];
	logic [31:0]        col_istep [COLUMNS];
	bit                 col_known [COLUMNS];

	interp_result_t expected_results[$];
	int  error_count;
	int  items_sent;
	int  evals_checked;
	int  short_seen;
	int  beyond_seen;
	int  idle_cycles;
	int  hold_cycles;
	bit  no_gaps;
	bit  timed_out;

	tabulated_pair_potential_interp DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .column(column), .distance_sq(distance_sq),
		.row(row), .entry_value(entry_value), .start_sq(start_sq),
		.step_sq(step_sq), .inverse_step(inverse_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.potential(potential), .gradient(gradient),
		.too_short(too_short), .beyond_table(beyond_table)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_gaps || p < 60) begin
			return 0;
		end
		if (p < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [63:0] magnitude(input longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint shift_toward_zero(input longint x, input int s);
		logic [63:0] m;
		m = magnitude(x) >> s;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Product with a Q16.16 factor, truncated and capped at 2^62.
	function automatic logic [63:0] scale_capped(input logic [63:0] m,
			input logic [31:0] f);
		logic [63:0] hi_part, lo_part, sum, cap;
		cap = 64'd1 << 62;
		hi_part = (m >> 32) * {32'd0, f};
		lo_part = {32'd0, m[31:0]} * {32'd0, f};
		if (hi_part > (cap >> (32 - FRAC_BITS))) begin
			return cap;
		end
		sum = (hi_part << (32 - FRAC_BITS)) + (lo_part >> FRAC_BITS);
		return (sum > cap) ? cap : sum;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > longint'(32'sh7FFFFFFF)) begin
			return 32'sh7FFFFFFF;
		end
		if (x < -longint'(64'd2147483648)) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic [63:0] offset_of(input int c, input logic [31:0] r2);
		return (r2 < col_start[c]) ? 64'd0 : {32'd0, r2 - col_start[c]};
	endfunction

	function automatic logic [63:0] base_row(input int c, input logic [31:0] r2);
		return (offset_of(c, r2) * {32'd0, col_istep[c]}) >> (2 * FRAC_BITS);
	endfunction

	function automatic interp_result_t interpolate(input int c, input logic [31:0] r2);
		interp_result_t res;
		logic [63:0] r2a, k, cm;
		longint diff, chi, p0, p1, p2, dv, d2v, inner, grd, pt, one, half;
		one = longint'(1) << FRAC_BITS;
		half = longint'(1) << (FRAC_BITS - 1);
		res = '0;
		res.beyond_flag = 1'b1;
		res.short_flag = (r2 < col_start[c]);
		r2a = offset_of(c, r2);
		k = base_row(c, r2);
		if (k >= TABLE_ROWS - 2) begin
			return res;
		end
		res.beyond_flag = 1'b0;
		diff = longint'(r2a) - longint'(k * {32'd0, col_step[c]});
		cm = scale_capped(magnitude(diff), col_istep[c]);
		if (cm > 64'(2 * one)) begin
			cm = 64'(2 * one);
		end
		chi = (diff < 0) ? -longint'(cm) : longint'(cm);
		p0 = pot_table[int'(k) * COLUMNS + c];
		p1 = pot_table[(int'(k) + 1) * COLUMNS + c];
		p2 = pot_table[(int'(k) + 2) * COLUMNS + c];
		dv = p1 - p0;
		d2v = p2 - 2 * p1 + p0;
		inner = dv + shift_toward_zero((chi - half) * d2v, FRAC_BITS);
		cm = scale_capped(2 * magnitude(inner), col_istep[c]);
		grd = (inner < 0) ? -longint'(cm) : longint'(cm);
		pt = p0 + shift_toward_zero(chi * dv, FRAC_BITS)
			+ shift_toward_zero(shift_toward_zero(chi * (chi - one), FRAC_BITS) * d2v,
				FRAC_BITS + 1);
		res.pot = clamp32(pt);
		res.grad = clamp32(grd);
		return res;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [3:0] c,
			input logic [31:0] r2, input logic [9:0] r, input logic [31:0] val,
			input logic [31:0] st, input logic [31:0] sp, input logic [31:0] is);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		column <= c;
		distance_sq <= r2;
		row <= r;
		entry_value <= val;
		start_sq <= st;
		step_sq <= sp;
		inverse_step <= is;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		unique case (op)
			tppi_pkg::OP_WRITE_ENTRY: begin
				pot_table[int'(r) * COLUMNS + c] = val;
				row_known[int'(r) * COLUMNS + c] = 1'b1;
			end
			tppi_pkg::OP_WRITE_COLUMN: begin
				col_start[c] = st;
				col_step[c] = sp;
				col_istep[c] = is;
				col_known[c] = 1'b1;
			end
			tppi_pkg::OP_EVAL: expected_results.push_back(interpolate(c, r2));
			default: ;
		endcase
	endtask

	task automatic write_entry(input int c, input int r, input logic [31:0] val);
		send_item(tppi_pkg::OP_WRITE_ENTRY, 4'(c), $urandom, 10'(r), val, $urandom,
			$urandom, $urandom);
	endtask

	task automatic write_column(input int c, input logic [31:0] st,
			input logic [31:0] sp, input logic [31:0] is);
		send_item(tppi_pkg::OP_WRITE_COLUMN, 4'(c), $urandom, 10'($urandom), $urandom,
			st, sp, is);
	endtask

	// Writes any row the evaluation would read that has not been written yet.
	task automatic evaluate(input int c, input logic [31:0] r2);
		logic [63:0] k;
		if (!col_known[c]) begin
			write_column(c, 0, 32'h10000, 32'h10000);
		end
		k = base_row(c, r2);
		if (k < TABLE_ROWS - 2) begin
			for (int i = 0; i < 3; i++) begin
				if (!row_known[(int'(k) + i) * COLUMNS + c]) begin
					write_entry(c, int'(k) + i, $urandom);
				end
			end
		end
		send_item(tppi_pkg::OP_EVAL, 4'(c), r2, 10'($urandom), $urandom, $urandom,
			$urandom, $urandom);
	endtask

	function automatic logic [31:0] random_distance(input int c);
		logic [63:0] off;
		int p;
		p = $urandom_range(0, 99);
		if (p < 15 && col_start[c] > 0) begin
			return $urandom_range(0, col_start[c] - 1);
		end
		if (p < 30) begin
			return $urandom;
		end
		off = {32'd0, col_step[c]} * $urandom_range(0, 1030)
			+ $urandom_range(0, col_step[c] - 1);
		off = off + col_start[c];
		return (off > 64'hFFFFFFFF) ? 32'hFFFFFFFF : off[31:0];
	endfunction

	task automatic random_column(input int c);
		logic [31:0] sp, is;
		logic [63:0] q;
		sp = $urandom_range(1, 1 << $urandom_range(4, 22));
		q = (64'd1 << 32) / sp;
		if ($urandom_range(0, 9) == 0) begin
			is = $urandom_range(1, 32'hFFFFFFFF);
		end else begin
			q = q + $urandom_range(0, 4) - 2;
			is = (q == 0) ? 32'd1 : (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
		end
		write_column(c, $urandom_range(0, 1 << $urandom_range(0, 31)), sp, is);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		write_column(0, 0, 32'h10000, 32'h10000);
		write_entry(0, 0, 32'h7FFFFFFF);
		write_entry(0, 1, 32'h80000000);
		write_entry(0, 2, 32'h7FFFFFFF);
		evaluate(0, 32'h8000);
		evaluate(0, 32'h0);
		evaluate(0, 32'hFFFFFFFF);
		write_column(15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
		evaluate(15, 32'h0);
		evaluate(15, 32'hFFFFFFFF);
		write_column(5, 32'h100, 32'd1, 32'hFFFFFFFF);
		evaluate(5, 32'h100);
		evaluate(5, 32'h101);
		evaluate(5, 32'h4FF);
		write_entry(10, 1023, 32'h5555AAAA);
		send_item(tppi_pkg::OP_UNUSED, 4'd3, $urandom, 10'($urandom), $urandom,
			$urandom, $urandom, $urandom);
		evaluate(0, 32'h3FD8000);
		drain();
	endtask

	task automatic test_random_traffic();
		int p, c;
		for (int i = 0; i < COLUMNS; i++) begin
			random_column(i);
		end
		while (items_sent < RANDOM_ITEMS) begin
			p = $urandom_range(0, 99);
			c = $urandom_range(0, COLUMNS - 1);
			if (p < 70) begin
				evaluate(c, random_distance(c));
			end else if (p < 88) begin
				write_entry(c, $urandom_range(0, TABLE_ROWS - 1), $urandom);
			end else if (p < 96) begin
				random_column(c);
			end else begin
				send_item(tppi_pkg::OP_UNUSED, 4'(c), $urandom, 10'($urandom), $urandom,
					$urandom, $urandom, $urandom);
			end
		end
		drain();
	endtask

	task automatic test_back_to_back();
		int c;
		no_gaps = 1'b1;
		for (int i = 0; i < 60; i++) begin
			c = $urandom_range(0, COLUMNS - 1);
			evaluate(c, random_distance(c));
		end
		no_gaps = 1'b0;
		drain();
	endtask

	task automatic test_output_stall();
		int c;
		hold_cycles = 300;
		no_gaps = 1'b1;
		for (int i = 0; i < 40; i++) begin
			c = $urandom_range(0, COLUMNS - 1);
			evaluate(c, random_distance(c));
		end
		no_gaps = 1'b0;
		drain();
	endtask

	// Receiver: random stalls, a forced hold-off when asked, and the checker.
	initial begin
		int stall;
		interp_result_t exp_r;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("Unexpected output transfer");
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					evals_checked++;
					short_seen += exp_r.short_flag;
					beyond_seen += exp_r.beyond_flag;
					if (potential !== exp_r.pot) begin
						$error("potential: expected %0d, got %0d", exp_r.pot, potential);
						error_count++;
					end
					if (gradient !== exp_r.grad) begin
						$error("gradient: expected %0d, got %0d", exp_r.grad, gradient);
						error_count++;
					end
					if (too_short !== exp_r.short_flag) begin
						$error("too_short: expected %0b, got %0b", exp_r.short_flag,
							too_short);
						error_count++;
					end
					if (beyond_table !== exp_r.beyond_flag) begin
						$error("beyond_table: expected %0b, got %0b", exp_r.beyond_flag,
							beyond_table);
						error_count++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 9) == 0) begin
					stall = pick_gap();
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		timed_out = 1'b0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				timed_out = 1'b1;
			end
		end
	end

	initial begin
		wait (timed_out);
		$display("tb_tabulated_pair_potential_interp: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = tppi_pkg::OP_EVAL;
		column = '0;
		distance_sq = '0;
		row = '0;
		entry_value = '0;
		start_sq = '0;
		step_sq = '0;
		inverse_step = '0;
		error_count = 0;
		items_sent = 0;
		evals_checked = 0;
		short_seen = 0;
		beyond_seen = 0;
		hold_cycles = 0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_traffic();
		test_back_to_back();
		test_output_stall();
		repeat (20) @(posedge clk);
		$display("Sent %0d items; checked %0d evaluations, %0d below start, %0d past table end.",
			items_sent, evals_checked, short_seen, beyond_seen);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("tb_tabulated_pair_potential_interp: PASS");
		end else begin
			$display("tb_tabulated_pair_potential_interp: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
